>>> src/utf8_to_display_char_filter_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 display filter assertion macros
// Concurrent check helpers shared by the filter RTL. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_DISPLAY_CHAR_FILTER_DEFINES_SVH
`define UTF8_TO_DISPLAY_CHAR_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is ignored while reset is high.
`define U2DC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also holds across reset.
`define U2DC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U2DC_ASSERT(name, prop, msg)
`define U2DC_ASSERT_RST(name, prop, msg)
`endif

`endif

>>> src/u2dc_pkg.sv
// ----------------------------------------------------------------------------
// u2dc_pkg
// Types, constants and byte mapping functions of the UTF-8 display filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u2dc_pkg;

  // Decoder mode between bytes.
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_AFTER_C3 = 2'd1,
    MODE_SKIP     = 2'd2
  } mode_t;

  localparam logic [7:0] LEAD_C3    = 8'hC3;
  localparam logic [7:0] BAD_C0     = 8'hC0;
  localparam logic [7:0] BAD_C1     = 8'hC1;
  localparam logic [7:0] BAD_MIN    = 8'hF5;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_O     = 8'h6F;

  // Plain ASCII: newline becomes a space, other control codes a tilde.
  function automatic logic [7:0] map_ascii(input logic [7:0] b);
    logic [7:0] r;
    if (b == CHAR_LF) begin
      r = CHAR_SPACE;
    end else if (b < CHAR_SPACE || b == CHAR_DEL) begin
      r = CHAR_TILDE;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // 2nd byte after 0xC3: umlauted or ringed a and umlauted o fold to plain a, o.
  function automatic logic [7:0] map_after_c3(input logic [7:0] b);
    logic [7:0] r;
    case (b) inside
      8'h84, 8'h85, 8'hA4, 8'hA5: r = CHAR_A;
      8'h96, 8'hB6:               r = CHAR_O;
      default:                    r = CHAR_TILDE;
    endcase
    return r;
  endfunction

  // Continuation bytes that follow a lead byte.
  function automatic logic [1:0] extra_bytes(input logic [7:0] b);
    logic [1:0] r;
    case (b) inside
      [8'h00:8'hBF]: r = 2'd0;
      [8'hC0:8'hDF]: r = 2'd1;
      [8'hE0:8'hEF]: r = 2'd2;
      default:       r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/u2dc_in_if.sv
// ----------------------------------------------------------------------------
// u2dc_in_if
// Byte channel into the filter: one raw byte and an end-of-string mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface u2dc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

>>> src/u2dc_out_if.sv
// ----------------------------------------------------------------------------
// u2dc_out_if
// Character channel out of the filter: one display character per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface u2dc_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] glyph;
  logic       last_out;

  modport source (output valid, output char_valid, output glyph,
                  output last_out, input ready);
  modport sink   (input valid, input char_valid, input glyph,
                  input last_out, output ready);
endinterface

`default_nettype wire

>>> src/utf8_to_display_char_filter.sv
// ----------------------------------------------------------------------------
// utf8_to_display_char_filter
// Maps a UTF-8 byte stream to display characters, one result item per byte.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   in_ch     sink       in_byte[7:0], end_of_string
//   out_ch    source     char_valid, glyph[7:0], last_out
//
// One item per cycle unless the output stalls: the decode mode update and the
// character mapping are a single level of logic between the mode registers and
// the result register, and the result is valid in the cycle after acceptance.
// A new item is taken while the result register is empty or being drained.
// Synchronous reset returns the decoder to idle and empties the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_display_char_filter_defines.svh"

module utf8_to_display_char_filter (
  input  wire logic clk,
  input  wire logic rst,
  u2dc_in_if.sink   in_ch,
  u2dc_out_if.source out_ch
);
  import u2dc_pkg::*;

  mode_t      mode;
  mode_t      mode_next;
  logic [1:0] skip_left;
  logic [1:0] skip_left_next;
  logic       in_acc;
  logic       ch_valid;
  logic [7:0] ch;

  logic       out_valid;
  logic       char_valid;
  logic [7:0] glyph;
  logic       last_out;

  // Accept while the result register is free or drains this cycle.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Decode one byte against the current mode.
  always_comb begin
    mode_next      = mode;
    skip_left_next = skip_left;
    ch_valid       = 1'b0;
    ch             = 8'h00;
    case (mode)
      MODE_AFTER_C3: begin
        mode_next = MODE_IDLE;
        if (in_ch.in_byte[7]) begin
          ch_valid = 1'b1;
          ch       = map_after_c3(in_ch.in_byte);
        end
      end
      MODE_SKIP: begin
        if (skip_left != 2'd0) begin
          skip_left_next = skip_left - 2'd1;
        end
        if (skip_left <= 2'd1) begin
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        if (in_ch.in_byte == BAD_C0 || in_ch.in_byte == BAD_C1 ||
            in_ch.in_byte >= BAD_MIN) begin
          ch_valid = 1'b0;
        end else if (!in_ch.in_byte[7]) begin
          ch_valid = 1'b1;
          ch       = map_ascii(in_ch.in_byte);
        end else if (in_ch.in_byte == LEAD_C3 && !in_ch.end_of_string) begin
          mode_next = MODE_AFTER_C3;
        end else begin
          ch_valid = 1'b1;
          ch       = CHAR_TILDE;
          if (in_ch.in_byte != LEAD_C3) begin
            skip_left_next = extra_bytes(in_ch.in_byte);
            if (extra_bytes(in_ch.in_byte) != 2'd0) begin
              mode_next = MODE_SKIP;
            end
          end
        end
      end
    endcase
    // The end mark closes the string and clears any pending sequence.
    if (in_ch.end_of_string) begin
      mode_next      = MODE_IDLE;
      skip_left_next = 2'd0;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      skip_left <= 2'd0;
    end else if (in_acc) begin
      mode      <= mode_next;
      skip_left <= skip_left_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      char_valid <= ch_valid;
      glyph      <= ch;
      last_out   <= in_ch.end_of_string;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.char_valid = char_valid;
  assign out_ch.glyph      = glyph;
  assign out_ch.last_out   = last_out;

  // Checks.
  `U2DC_ASSERT(a_end_clears, (in_acc && in_ch.end_of_string) |=> (mode == MODE_IDLE && skip_left == 2'd0), "end mark did not clear decoder state")
  `U2DC_ASSERT(a_skip_count, (mode == MODE_SKIP) |-> (skip_left != 2'd0), "skip mode with no bytes left")
  `U2DC_ASSERT(a_empty_char, (out_valid && !char_valid) |-> (glyph == 8'h00), "dropped item carries a character")
  `U2DC_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

`default_nettype wire
